[hw/rtl/shnf_pkg.sv]
// shared types, constants and codes for the spatial hash neighbor finder
package shnf_pkg;

    localparam int MAX_BUCKETS_DEF = 4096;
    localparam int MAX_POINTS_DEF  = 1024;

    localparam int COORD_W  = 32;
    localparam int CNT_W    = 13;
    localparam int IDX_W    = 10;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_PREP,
        S_CRD_RD,
        S_DIV,
        S_DIV_DONE,
        S_WRITE,
        S_RSCAN,
        S_LSCAN,
        S_DONE
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic load_item;
        logic crd_rd;
        logic div_start;
        logic div_step;
        logic write_ins;
        logic rscan_init;
        logic scan_step;
        logic lscan_init;
        logic emit;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic full;
        logic unknown;
        logic in_range;
        logic scan_hit;
        logic scan_end;
    } sts_t;

endpackage

[hw/rtl/spatial_hash_neighbor_finder.sv]
// top level of the spatial hash neighbor finder
//
// channel   signals                                   direction
// command   start, busy, kind, coordinate, point_index  in (busy out)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   in (ready out)
// result    result_valid, left_index, right_index,
//           assigned_index, status                      out
//
// an insert runs through the 32-step bucket divider
// a query runs the same divider, then scans buckets on each side
// a clear sweeps the bucket table; reset runs the same sweep
// results strobe for one cycle; the receiver cannot stall, config is always ready
module spatial_hash_neighbor_finder #(
    parameter int MAX_BUCKETS = shnf_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_POINTS  = shnf_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [shnf_pkg::KIND_W-1:0]     kind,
    input  logic [shnf_pkg::COORD_W-1:0]    coordinate,
    input  logic [shnf_pkg::IDX_W-1:0]      point_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [shnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [shnf_pkg::COORD_W-1:0]    cfg_data,
    output logic                            result_valid,
    output logic [shnf_pkg::IDX_W-1:0]      left_index,
    output logic [shnf_pkg::IDX_W-1:0]      right_index,
    output logic [shnf_pkg::IDX_W-1:0]      assigned_index,
    output logic [shnf_pkg::STAT_W-1:0]     status
);
    import shnf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // controller
    shnf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath
    shnf_dp #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_POINTS  (MAX_POINTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .kind           (kind),
        .coordinate     (coordinate),
        .point_index    (point_index),
        .cfg_wr         (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .left_index     (left_index),
        .right_index    (right_index),
        .assigned_index (assigned_index),
        .status         (status)
    );

endmodule

[hw/rtl/shnf_ctrl.sv]
// controller state machine for the spatial hash neighbor finder
module shnf_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [shnf_pkg::KIND_W-1:0]   kind,
    input  shnf_pkg::sts_t                sts,
    output shnf_pkg::cmd_t                cmd,
    output logic                          busy
);
    import shnf_pkg::*;

    state_t state_reg, state_next;
    logic   is_query_reg, is_query_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            is_query_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            is_query_reg <= is_query_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        is_query_next = is_query_reg;
        cmd           = '0;
        busy          = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    case (kind)
                        KIND_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        KIND_INSERT:
                        begin
                            is_query_next = 1'b0;
                            state_next    = S_PREP;
                        end
                        KIND_QUERY:
                        begin
                            is_query_next = 1'b1;
                            state_next    = S_PREP;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_PREP:
            begin
                if (is_query_reg)
                begin
                    if (sts.unknown)
                        state_next = S_DONE;
                    else
                    begin
                        cmd.crd_rd = 1'b1;
                        state_next = S_CRD_RD;
                    end
                end
                else if (sts.full)
                    state_next = S_DONE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_CRD_RD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_DIV_DONE;
            end
            S_DIV_DONE:
            begin
                if (!sts.in_range)
                    state_next = S_DONE;
                else if (is_query_reg)
                begin
                    cmd.rscan_init = 1'b1;
                    state_next     = S_RSCAN;
                end
                else
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write_ins = 1'b1;
                state_next    = S_DONE;
            end
            S_RSCAN:
            begin
                if (sts.scan_hit || sts.scan_end)
                begin
                    cmd.lscan_init = 1'b1;
                    state_next     = S_LSCAN;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_LSCAN:
            begin
                if (sts.scan_hit || sts.scan_end)
                    state_next = S_DONE;
                else
                    cmd.scan_step = 1'b1;
            end
            S_DONE:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // write and scan never overlap
    a_write_not_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_ins |-> !cmd.scan_step)
        else $error("write during scan");

    // a result closes every insert or query episode into idle
    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> !busy)
        else $error("emit not followed by idle");

    // items only taken when idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |-> (state_reg == S_IDLE))
        else $error("load outside idle");

endmodule

[hw/rtl/shnf_dp.sv]
// datapath: registers, bucket table, coordinate store, divider, scanner
module shnf_dp #(
    parameter int MAX_BUCKETS = shnf_pkg::MAX_BUCKETS_DEF,
    parameter int MAX_POINTS  = shnf_pkg::MAX_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  shnf_pkg::cmd_t                  cmd,
    output shnf_pkg::sts_t                  sts,
    input  logic [shnf_pkg::KIND_W-1:0]     kind,
    input  logic [shnf_pkg::COORD_W-1:0]    coordinate,
    input  logic [shnf_pkg::IDX_W-1:0]      point_index,
    input  logic                            cfg_wr,
    input  logic [shnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [shnf_pkg::COORD_W-1:0]    cfg_data,
    output logic                            result_valid,
    output logic [shnf_pkg::IDX_W-1:0]      left_index,
    output logic [shnf_pkg::IDX_W-1:0]      right_index,
    output logic [shnf_pkg::IDX_W-1:0]      assigned_index,
    output logic [shnf_pkg::STAT_W-1:0]     status
);
    import shnf_pkg::*;

    localparam int BA_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int PA_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PC_W = $clog2(MAX_POINTS + 1);
    localparam int BN_W = $clog2(MAX_BUCKETS + 1);
    localparam int TE_W = PA_W + 1;
    localparam int DC_W = 6;

    // configuration registers
    logic [COORD_W-1:0] origin_reg;
    logic [COORD_W-1:0] width_reg;
    logic [CNT_W-1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            width_reg  <= 32'd65536;
            count_reg  <= 13'd4096;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_ORIGIN: origin_reg <= cfg_data;
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_COUNT:  count_reg  <= cfg_data[CNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // buckets in use, clamped to the table depth
    logic [BN_W-1:0] n_use;
    always_comb
    begin
        if ({19'd0, count_reg} > 32'(MAX_BUCKETS))
            n_use = BN_W'(MAX_BUCKETS);
        else
            n_use = BN_W'(count_reg);
    end

    // item registers
    logic [COORD_W-1:0] crd_reg;
    logic [IDX_W-1:0]   pidx_reg;
    logic               query_reg;
    logic               ins_done_reg;
    logic [PC_W-1:0]    pcount_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            crd_reg      <= coordinate;
            pidx_reg     <= point_index;
            query_reg    <= (kind == KIND_QUERY);
            ins_done_reg <= 1'b0;
        end
        else if (cmd.write_ins)
            ins_done_reg <= 1'b1;
    end

    // coordinate store, read data registered
    logic [COORD_W-1:0] crd_mem [MAX_POINTS];
    logic [COORD_W-1:0] crd_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write_ins)
            crd_mem[pcount_reg[PA_W-1:0]] <= crd_reg;
        if (cmd.crd_rd)
            crd_rd_reg <= crd_mem[pidx_reg[PA_W-1:0]];
    end

    assign sts.full    = (pcount_reg >= PC_W'(MAX_POINTS));
    assign sts.unknown = ({22'd0, pidx_reg} >= 32'(pcount_reg))
                         || ({22'd0, pidx_reg} >= 32'(MAX_POINTS));

    // restoring divider, one quotient bit per cycle
    logic [COORD_W-1:0] num_reg;
    logic [COORD_W:0]   rem_reg;
    logic [COORD_W-1:0] quo_reg;
    logic [DC_W-1:0]    dcnt_reg;
    logic               below_reg;
    logic [COORD_W-1:0] div_src;
    logic [COORD_W:0]   rem_sh;

    assign div_src = query_reg ? crd_rd_reg : crd_reg;
    assign rem_sh  = {rem_reg[COORD_W-1:0], num_reg[COORD_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg   <= div_src - origin_reg;
            below_reg <= (div_src < origin_reg);
            rem_reg   <= '0;
            quo_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg  <= {num_reg[COORD_W-2:0], 1'b0};
            dcnt_reg <= dcnt_reg + 1'b1;
            if (rem_sh >= {1'b0, width_reg})
            begin
                rem_reg <= rem_sh - {1'b0, width_reg};
                quo_reg <= {quo_reg[COORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[COORD_W-2:0], 1'b0};
            end
        end
    end

    assign sts.div_last = (dcnt_reg == DC_W'(COORD_W - 1));
    assign sts.in_range = !below_reg && (width_reg != '0)
                          && (quo_reg < 32'(n_use));

    // bucket table with valid bits cleared by a sweep
    logic [TE_W-1:0] tab_mem [MAX_BUCKETS];
    logic [BA_W-1:0] clr_addr_reg;
    logic [BA_W-1:0] tab_addr;
    logic [BA_W-1:0] scan_reg;
    logic [TE_W-1:0] tab_rd;
    logic            tab_we;
    logic [TE_W-1:0] tab_wd;
    logic [BA_W-1:0] bucket;

    assign bucket = quo_reg[BA_W-1:0];

    always_comb
    begin
        tab_we   = 1'b0;
        tab_wd   = '0;
        tab_addr = scan_reg;
        if (cmd.clr_step)
        begin
            tab_we   = 1'b1;
            tab_addr = clr_addr_reg;
        end
        else if (cmd.write_ins)
        begin
            tab_we   = 1'b1;
            tab_wd   = {1'b1, pcount_reg[PA_W-1:0]};
            tab_addr = bucket;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
            tab_mem[tab_addr] <= tab_wd;
        tab_rd <= tab_mem[tab_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_start)
            clr_addr_reg <= '0;
        else if (cmd.clr_step)
            clr_addr_reg <= clr_addr_reg + 1'b1;
    end
    assign sts.clr_last = (clr_addr_reg == BA_W'(MAX_BUCKETS - 1));

    // point count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pcount_reg <= '0;
        else if (cmd.clr_start)
            pcount_reg <= '0;
        else if (cmd.write_ins)
            pcount_reg <= pcount_reg + 1'b1;
    end

    // scanner: one bucket per read, a bucket address and a pending flag
    logic            dir_up_reg;
    logic            pend_reg;
    logic            sdone_reg;
    logic [IDX_W-1:0] left_reg, right_reg;
    logic [BN_W:0]   nxt_up;

    assign nxt_up = {1'b0, {1'b0, scan_reg}} + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.rscan_init)
        begin
            dir_up_reg <= 1'b1;
            left_reg   <= pidx_reg;
            right_reg  <= pidx_reg;
            if (32'(bucket) + 32'd1 < 32'(n_use))
            begin
                scan_reg  <= bucket + 1'b1;
                pend_reg  <= 1'b1;
                sdone_reg <= 1'b0;
            end
            else
            begin
                pend_reg  <= 1'b0;
                sdone_reg <= 1'b1;
            end
        end
        else if (cmd.lscan_init)
        begin
            dir_up_reg <= 1'b0;
            if (sts.scan_hit)
                right_reg <= IDX_W'(tab_rd[PA_W-1:0]);
            if (bucket != '0)
            begin
                scan_reg  <= bucket - 1'b1;
                pend_reg  <= 1'b1;
                sdone_reg <= 1'b0;
            end
            else
            begin
                pend_reg  <= 1'b0;
                sdone_reg <= 1'b1;
            end
        end
        else if (cmd.scan_step)
        begin
            // read issued this cycle for scan_reg; data valid next cycle
            if (pend_reg)
                pend_reg <= 1'b0;
            else if (dir_up_reg)
            begin
                if (nxt_up < (BN_W+1)'(n_use))
                begin
                    scan_reg <= scan_reg + 1'b1;
                    pend_reg <= 1'b1;
                end
                else
                    sdone_reg <= 1'b1;
            end
            else
            begin
                if (scan_reg != '0)
                begin
                    scan_reg <= scan_reg - 1'b1;
                    pend_reg <= 1'b1;
                end
                else
                    sdone_reg <= 1'b1;
            end
        end
        else if (sts.scan_hit && !dir_up_reg && !sdone_reg)
            left_reg <= IDX_W'(tab_rd[PA_W-1:0]);
    end

    assign sts.scan_hit = !pend_reg && !sdone_reg && tab_rd[TE_W-1];
    assign sts.scan_end = sdone_reg;

    // result register, one beat per emit
    logic [STAT_W-1:0] stat_c;
    logic [IDX_W-1:0]  l_c, r_c, a_c;
    always_comb
    begin
        l_c = '0;
        r_c = '0;
        a_c = '0;
        stat_c = ST_OK;
        if (query_reg)
        begin
            if (sts.unknown)
                stat_c = ST_UNKNOWN;
            else if (!sts.in_range)
            begin
                stat_c = ST_RANGE;
                l_c    = pidx_reg;
                r_c    = pidx_reg;
            end
            else
            begin
                r_c = right_reg;
                l_c = (sts.scan_hit && !dir_up_reg)
                      ? IDX_W'(tab_rd[PA_W-1:0]) : left_reg;
            end
        end
        else
        begin
            // the count has already moved on for a stored point
            if (ins_done_reg)
                a_c = IDX_W'(pcount_reg - 1'b1);
            else if (sts.full)
                stat_c = ST_FULL;
            else
                stat_c = ST_RANGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else
            result_valid <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            left_index     <= l_c;
            right_index    <= r_c;
            assigned_index <= a_c;
            status         <= stat_c;
        end
    end

    // point count never exceeds the store
    a_pcount: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= PC_W'(MAX_POINTS))
        else $error("point count overflow");

    // an insert write only happens with room and in range
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_ins |-> (!sts.full && sts.in_range))
        else $error("bad insert write");

    // result strobe follows emit in the next cycle
    a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> result_valid)
        else $error("missing result strobe");

endmodule
